FILE: hdl/crtb_pkg.sv
`default_nettype none

package crtb_pkg;

    localparam int NUM_TIMERS_DEF = 4;

    localparam int COUNT_W   = 16;
    localparam int PRESC_W   = 10;
    localparam int PERIOD_W  = PRESC_W + 1;
    localparam int IRQ_W     = 4;
    localparam int OP_W      = 2;
    localparam int INDEX_W   = 2;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam int CTRL_SEL_LO  = 0;
    localparam int CTRL_CASCADE = 2;
    localparam int CTRL_IRQ_EN  = 6;
    localparam int CTRL_ENABLE  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_RELOAD = 2'd1,
        OP_CTRL   = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PSC_DIV1    = 2'd0,
        PSC_DIV64   = 2'd1,
        PSC_DIV256  = 2'd2,
        PSC_DIV1024 = 2'd3
    } presc_sel_t;

    function automatic logic [PERIOD_W-1:0] period_of(input logic [1:0] sel);
        logic [PERIOD_W-1:0] p;
        case (presc_sel_t'(sel))
            PSC_DIV64:   p = PERIOD_W'(1) << 6;
            PSC_DIV256:  p = PERIOD_W'(1) << 8;
            PSC_DIV1024: p = PERIOD_W'(1) << 10;
            default:     p = PERIOD_W'(1);
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/cascadable_reload_timer_bank.sv
`default_nettype none
// A beat is held in the input register, and its result in the result register.
// Throughput: one beat per cycle; the input register and result register form
// a two-stage pipe that advances whenever the result register is empty or taken.
// Overflow ripple through cascaded timers settles combinationally in one update.
// Reset: rst_n asynchronous, active low; clears all timers (stopped, zero counts,
// zero reloads) and empties both pipe stages.
module cascadable_reload_timer_bank #(
    parameter int NUM_TIMERS = crtb_pkg::NUM_TIMERS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] write_data
    input  wire  [crtb_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [1:0] op, [3:2] timer_index
    input  wire  [crtb_pkg::OP_W+crtb_pkg::INDEX_W-1:0] s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // [15:0] read_data, [19:16] overflow_irq, [23:20] zero
    output logic [crtb_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import crtb_pkg::*;

    logic                  in_valid_reg;
    logic [OP_W-1:0]       in_op_reg;
    logic [INDEX_W-1:0]    in_idx_reg;
    logic [IN_DATA_W-1:0]  in_data_reg;

    logic                  out_valid_reg;
    logic [COUNT_W-1:0]    out_rd_reg;
    logic [IRQ_W-1:0]      out_irq_reg;

    logic [COUNT_W-1:0]    count_reg      [NUM_TIMERS];
    logic [COUNT_W-1:0]    count_next     [NUM_TIMERS];
    logic [COUNT_W-1:0]    reload_reg     [NUM_TIMERS];
    logic [COUNT_W-1:0]    reload_next    [NUM_TIMERS];
    logic [PRESC_W-1:0]    presc_cnt_reg  [NUM_TIMERS];
    logic [PRESC_W-1:0]    presc_cnt_next [NUM_TIMERS];
    logic [1:0]            presc_sel_reg  [NUM_TIMERS];
    logic [1:0]            presc_sel_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] cascade_reg;
    logic [NUM_TIMERS-1:0] cascade_next;
    logic [NUM_TIMERS-1:0] irq_en_reg;
    logic [NUM_TIMERS-1:0] irq_en_next;
    logic [NUM_TIMERS-1:0] running_reg;
    logic [NUM_TIMERS-1:0] running_next;
    logic [NUM_TIMERS-1:0] pending_reg;
    logic [NUM_TIMERS-1:0] pending_next;

    logic                  advance;
    logic                  exec;
    logic [COUNT_W-1:0]    rd_next;
    logic [NUM_TIMERS-1:0] irq_all;
    logic [IRQ_W-1:0]      irq_next;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign exec          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - COUNT_W - IRQ_W)'(0), out_irq_reg, out_rd_reg};

    always_comb
    begin
        logic                carry;
        logic                step;
        logic                hit;
        logic                en;
        logic                casc;
        logic [PERIOD_W-1:0] pc;

        count_next     = count_reg;
        reload_next    = reload_reg;
        presc_cnt_next = presc_cnt_reg;
        presc_sel_next = presc_sel_reg;
        cascade_next   = cascade_reg;
        irq_en_next    = irq_en_reg;
        running_next   = running_reg;
        pending_next   = pending_reg;
        rd_next        = '0;
        irq_all        = '0;
        carry          = 1'b0;
        step           = 1'b0;
        hit            = 1'b0;
        en             = in_data_reg[CTRL_ENABLE];
        casc           = in_data_reg[CTRL_CASCADE];
        pc             = '0;

        if (exec)
        begin
            case (op_t'(in_op_reg))
                OP_TICK:
                begin
                    for (int n = 0; n < NUM_TIMERS; n++)
                    begin
                        step = 1'b0;
                        if (running_reg[n])
                        begin
                            if (pending_reg[n])
                            begin
                                pending_next[n] = 1'b0;
                            end
                            else if (cascade_reg[n])
                            begin
                                step = carry;
                            end
                            else
                            begin
                                pc = {1'b0, presc_cnt_reg[n]} + PERIOD_W'(1);
                                if (pc >= period_of(presc_sel_reg[n]))
                                begin
                                    presc_cnt_next[n] = '0;
                                    step = 1'b1;
                                end
                                else
                                begin
                                    presc_cnt_next[n] = pc[PRESC_W-1:0];
                                end
                            end
                        end
                        carry = 1'b0;
                        if (step)
                        begin
                            if (count_reg[n] == COUNT_MAX)
                            begin
                                count_next[n] = reload_reg[n];
                                irq_all[n]    = irq_en_reg[n];
                                carry         = 1'b1;
                            end
                            else
                            begin
                                count_next[n] = count_reg[n] + COUNT_W'(1);
                            end
                        end
                    end
                end
                OP_RELOAD:
                begin
                    for (int n = 0; n < NUM_TIMERS; n++)
                    begin
                        if (32'(in_idx_reg) == n)
                        begin
                            reload_next[n] = in_data_reg[COUNT_W-1:0];
                        end
                    end
                end
                OP_CTRL:
                begin
                    for (int n = 0; n < NUM_TIMERS; n++)
                    begin
                        if (32'(in_idx_reg) == n)
                        begin
                            presc_sel_next[n] = in_data_reg[CTRL_SEL_LO +: 2];
                            irq_en_next[n]    = in_data_reg[CTRL_IRQ_EN];
                            cascade_next[n]   = casc;
                            if (running_reg[n] && !en)
                            begin
                                running_next[n] = 1'b0;
                                pending_next[n] = 1'b0;
                            end
                            if (cascade_reg[n] && !casc && running_reg[n] && en)
                            begin
                                presc_cnt_next[n] = '0;
                            end
                            if (!running_reg[n] && en)
                            begin
                                running_next[n]   = 1'b1;
                                pending_next[n]   = 1'b1;
                                count_next[n]     = reload_reg[n];
                                presc_cnt_next[n] = '0;
                            end
                        end
                    end
                end
                OP_READ:
                begin
                    for (int n = 0; n < NUM_TIMERS; n++)
                    begin
                        hit = (32'(in_idx_reg) == n);
                        if (hit)
                        begin
                            rd_next = count_reg[n];
                        end
                    end
                end
                default:
                begin
                    rd_next = '0;
                end
            endcase
        end
    end

    generate
        for (genvar i = 0; i < IRQ_W; i++)
        begin : g_irq
            if (i < NUM_TIMERS)
            begin : g_live
                assign irq_next[i] = irq_all[i];
            end
            else
            begin : g_none
                assign irq_next[i] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg   <= s_axis_tuser[OP_W-1:0];
            in_idx_reg  <= s_axis_tuser[OP_W +: INDEX_W];
            in_data_reg <= s_axis_tdata;
        end
        if (exec)
        begin
            out_rd_reg  <= rd_next;
            out_irq_reg <= irq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NUM_TIMERS; n++)
            begin
                count_reg[n]     <= '0;
                reload_reg[n]    <= '0;
                presc_cnt_reg[n] <= '0;
                presc_sel_reg[n] <= '0;
            end
            cascade_reg <= '0;
            irq_en_reg  <= '0;
            running_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            reload_reg    <= reload_next;
            presc_cnt_reg <= presc_cnt_next;
            presc_sel_reg <= presc_sel_next;
            cascade_reg   <= cascade_next;
            irq_en_reg    <= irq_en_next;
            running_reg   <= running_next;
            pending_reg   <= pending_next;
        end
    end

endmodule

`default_nettype wire

FILE: bench/tb.sv
`default_nettype none

module tb;

    import crtb_pkg::*;

    localparam int NT = NUM_TIMERS_DEF;

    typedef struct packed {
        logic [COUNT_W-1:0] read_data;
        logic [IRQ_W-1:0]   overflow_irq;
    } timer_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [IN_DATA_W-1:0]          s_axis_tdata = '0;
    logic [OP_W+INDEX_W-1:0]       s_axis_tuser = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]         m_axis_tdata;

    logic [COUNT_W-1:0] tmr_count      [NT];
    logic [COUNT_W-1:0] tmr_reload     [NT];
    logic [PRESC_W-1:0] tmr_presc      [NT];
    presc_sel_t         tmr_sel        [NT];
    bit                 tmr_cascade    [NT];
    bit                 tmr_irq_en     [NT];
    bit                 tmr_running    [NT];
    bit                 tmr_start_pend [NT];

    timer_result_t expected_results[$];
    int            fail_count = 0;
    int            burst_left = 0;
    bit            hold_request = 1'b0;

    cascadable_reload_timer_bank #(
        .NUM_TIMERS(NT)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned divider(presc_sel_t s);
        case (s)
            PSC_DIV64:   return 64;
            PSC_DIV256:  return 256;
            PSC_DIV1024: return 1024;
            default:     return 1;
        endcase
    endfunction

    function automatic logic [IRQ_W-1:0] ripple_overflow(int k);
        logic [IRQ_W-1:0] irq;
        irq = '0;
        while (k < NT)
        begin
            tmr_count[k] = tmr_reload[k];
            if (tmr_irq_en[k] && k < IRQ_W)
                irq[k] = 1'b1;
            if (k + 1 >= NT)
                break;
            k++;
            if (!tmr_running[k] || tmr_start_pend[k] || !tmr_cascade[k])
                break;
            tmr_count[k] = tmr_count[k] + 1'b1;
            if (tmr_count[k] != '0)
                break;
        end
        return irq;
    endfunction

    function automatic timer_result_t timer_bank_step(op_t op, logic [INDEX_W-1:0] idx,
                                                      logic [IN_DATA_W-1:0] wd);
        timer_result_t r;
        logic [PRESC_W:0] pc;
        bit en;
        bit casc;
        bit was_running;
        r = '0;
        case (op)
            OP_TICK:
            begin
                for (int n = 0; n < NT; n++)
                begin
                    if (!tmr_running[n])
                        continue;
                    if (tmr_start_pend[n])
                    begin
                        tmr_start_pend[n] = 1'b0;
                        continue;
                    end
                    if (tmr_cascade[n])
                        continue;
                    pc = {1'b0, tmr_presc[n]} + 1'b1;
                    if (pc >= divider(tmr_sel[n]))
                    begin
                        tmr_presc[n] = '0;
                        if (tmr_count[n] == COUNT_MAX)
                            r.overflow_irq |= ripple_overflow(n);
                        else
                            tmr_count[n] = tmr_count[n] + 1'b1;
                    end
                    else
                    begin
                        tmr_presc[n] = pc[PRESC_W-1:0];
                    end
                end
            end
            OP_RELOAD:
            begin
                tmr_reload[idx] = wd;
            end
            OP_CTRL:
            begin
                en = wd[CTRL_ENABLE];
                casc = wd[CTRL_CASCADE];
                was_running = tmr_running[idx];
                tmr_sel[idx] = presc_sel_t'(wd[CTRL_SEL_LO +: 2]);
                tmr_irq_en[idx] = wd[CTRL_IRQ_EN];
                if (was_running && !en)
                begin
                    tmr_running[idx] = 1'b0;
                    tmr_start_pend[idx] = 1'b0;
                end
                if (tmr_cascade[idx] && !casc && was_running && en)
                    tmr_presc[idx] = '0;
                tmr_cascade[idx] = casc;
                if (!was_running && en)
                begin
                    tmr_running[idx] = 1'b1;
                    tmr_start_pend[idx] = 1'b1;
                    tmr_count[idx] = tmr_reload[idx];
                    tmr_presc[idx] = '0;
                end
            end
            default:
            begin
                r.read_data = tmr_count[idx];
            end
        endcase
        return r;
    endfunction

    function automatic logic [IN_DATA_W-1:0] ctrl_word(presc_sel_t s, bit casc, bit irq, bit en);
        logic [IN_DATA_W-1:0] w;
        w = '0;
        w[CTRL_SEL_LO +: 2] = s;
        w[CTRL_CASCADE] = casc;
        w[CTRL_IRQ_EN] = irq;
        w[CTRL_ENABLE] = en;
        return w;
    endfunction

    task automatic send_beat(op_t op, logic [INDEX_W-1:0] idx, logic [IN_DATA_W-1:0] wd);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                gap = 0;
                burst_left = $urandom_range(40, 100);
            end
            else
            begin
                gap = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 20);
            end
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= wd;
        s_axis_tuser <= {idx, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(timer_bank_step(op, idx, wd));
        burst_left--;
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_beat(OP_TICK, 2'($urandom), 16'($urandom));
    endtask

    // receiver: rotating stall pattern, plus long hold-offs on request
    initial
    begin
        logic [15:0] stall_pattern;
        int phase_left;
        int hold_left;
        stall_pattern = 16'hFFFF;
        phase_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left = 120;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_left = $urandom_range(16, 96);
                    case ($urandom_range(0, 3))
                        0:       stall_pattern = 16'hFFFF;
                        1:       stall_pattern = 16'hF0F7;
                        default: stall_pattern = 16'($urandom) | 16'h0001;
                    endcase
                end
                m_axis_tready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                phase_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        timer_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with no expectation: %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_axis_tdata[15:0] !== exp_r.read_data)
                begin
                    $error("read_data: expected %h, actual %h",
                           exp_r.read_data, m_axis_tdata[15:0]);
                    fail_count++;
                end
                if (m_axis_tdata[19:16] !== exp_r.overflow_irq)
                begin
                    $error("overflow_irq: expected %b, actual %b",
                           exp_r.overflow_irq, m_axis_tdata[19:16]);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_reset_state;
        for (int t = 0; t < NT; t++)
            send_beat(OP_READ, t[INDEX_W-1:0], 16'hFFFF);
        send_beat(OP_TICK, 2'd3, 16'hFFFF);
    endtask

    task automatic test_overflow_div1;
        send_beat(OP_RELOAD, 2'd0, 16'hFFFD);
        send_beat(OP_CTRL, 2'd0, ctrl_word(PSC_DIV1, 1'b0, 1'b1, 1'b1));
        send_ticks(4);
        send_beat(OP_READ, 2'd0, 16'h0000);
        // reload of all ones overflows on every step
        send_beat(OP_RELOAD, 2'd0, 16'hFFFF);
        send_ticks(5);
        send_beat(OP_READ, 2'd0, 16'h0000);
    endtask

    task automatic test_cascade_ripple;
        for (int t = 1; t < NT; t++)
        begin
            send_beat(OP_RELOAD, t[INDEX_W-1:0], 16'hFFFF);
            send_beat(OP_CTRL, t[INDEX_W-1:0], ctrl_word(PSC_DIV1024, 1'b1, 1'b1, 1'b1));
        end
        send_ticks(4);
        for (int t = 0; t < NT; t++)
            send_beat(OP_READ, t[INDEX_W-1:0], 16'h0000);
        // timer zero in cascade mode stalls the whole chain
        send_beat(OP_CTRL, 2'd0, ctrl_word(PSC_DIV1, 1'b1, 1'b1, 1'b1));
        send_ticks(3);
        send_beat(OP_READ, 2'd0, 16'h0000);
        // unused bits set, enable while running
        send_beat(OP_CTRL, 2'd0, 16'hFFFF);
        send_ticks(2);
        send_beat(OP_CTRL, 2'd0, 16'hFF3B);
        send_ticks(3);
        send_beat(OP_CTRL, 2'd3, ctrl_word(PSC_DIV1, 1'b0, 1'b0, 1'b0));
        send_ticks(3);
        send_beat(OP_READ, 2'd3, 16'h0000);
    endtask

    task automatic test_prescale_change;
        send_beat(OP_RELOAD, 2'd2, 16'h1234);
        // leave cascade while running: prescaler restarts
        send_beat(OP_CTRL, 2'd2, ctrl_word(PSC_DIV1024, 1'b0, 1'b0, 1'b1));
        send_ticks(300);
        send_beat(OP_READ, 2'd2, 16'h0000);
        send_beat(OP_CTRL, 2'd2, ctrl_word(PSC_DIV64, 1'b0, 1'b0, 1'b1));
        send_ticks(2);
        send_beat(OP_READ, 2'd2, 16'h0000);
        send_beat(OP_CTRL, 2'd2, ctrl_word(PSC_DIV256, 1'b0, 1'b1, 1'b1));
        send_ticks(260);
        send_beat(OP_CTRL, 2'd2, ctrl_word(PSC_DIV256, 1'b0, 1'b1, 1'b0));
        send_ticks(3);
        send_beat(OP_READ, 2'd2, 16'h0000);
    endtask

    task automatic test_backpressure;
        hold_request = 1'b1;
        for (int i = 0; i < 60; i++)
        begin
            if (i % 5 == 4)
                send_beat(OP_READ, 2'($urandom), 16'($urandom));
            else
                send_ticks(1);
        end
    endtask

    function automatic logic [IN_DATA_W-1:0] random_reload();
        if ($urandom_range(0, 3) != 0)
            return 16'hFFFF - 16'($urandom_range(0, 15));
        return 16'($urandom);
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_ctrl();
        logic [IN_DATA_W-1:0] w;
        w = 16'($urandom);
        if ($urandom_range(0, 4) != 0)
        begin
            w[CTRL_SEL_LO +: 2] = ($urandom_range(0, 9) < 7) ? PSC_DIV1 : 2'($urandom);
            w[CTRL_CASCADE] = ($urandom_range(0, 9) < 3);
            w[CTRL_IRQ_EN] = ($urandom_range(0, 9) < 7);
            w[CTRL_ENABLE] = ($urandom_range(0, 19) < 17);
        end
        return w;
    endfunction

    task automatic test_random_traffic;
        int items;
        int pick;
        bit held;
        logic [INDEX_W-1:0] idx;
        items = 0;
        held = 1'b0;
        while (items < 220)
        begin
            if (!held && items > 110)
            begin
                hold_request = 1'b1;
                held = 1'b1;
            end
            idx = 2'($urandom);
            if ($urandom_range(0, 1) == 1)
            begin
                send_beat(OP_RELOAD, idx, random_reload());
                items++;
            end
            send_beat(OP_CTRL, idx, random_ctrl());
            items++;
            repeat ($urandom_range(8, 40))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_ticks(1);
                else if (pick < 85)
                    send_beat(OP_READ, 2'($urandom), 16'($urandom));
                else if (pick < 92)
                    send_beat(OP_RELOAD, 2'($urandom), random_reload());
                else
                    send_beat(OP_CTRL, 2'($urandom), random_ctrl());
                items++;
            end
        end
    endtask

    initial
    begin
        for (int t = 0; t < NT; t++)
        begin
            tmr_count[t] = '0;
            tmr_reload[t] = '0;
            tmr_presc[t] = '0;
            tmr_sel[t] = PSC_DIV1;
            tmr_cascade[t] = 1'b0;
            tmr_irq_en[t] = 1'b0;
            tmr_running[t] = 1'b0;
            tmr_start_pend[t] = 1'b0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_overflow_div1();
        test_cascade_ripple();
        test_prescale_change();
        test_backpressure();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/crtb_pkg.sv
hdl/cascadable_reload_timer_bank.sv
bench/tb.sv
